// ----- rtl/core/sbfm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbfm_pkg
// Shared widths, reset values and register indexes for the supply and
// blower fault monitor.
// ----------------------------------------------------------------------------
package sbfm_pkg;

    // converter sample and average width
    localparam int SAMPLE_BITS    = 10;
    // default samples per averaging group
    localparam int GROUP_SIZE     = 4;
    // debounce counter and debounce register width
    localparam int DEBOUNCE_BITS  = 8;
    // width of the tolerance window arithmetic (wraps like a 16-bit word)
    localparam int WRAP_BITS      = 16;

    // configuration channel
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0]   OVER_THRESHOLD_RST  = SAMPLE_BITS'(600);
    localparam logic [SAMPLE_BITS-1:0]   UNDER_THRESHOLD_RST = SAMPLE_BITS'(294);
    localparam logic [SAMPLE_BITS-1:0]   RECOVER_LOW_RST     = SAMPLE_BITS'(312);
    localparam logic [SAMPLE_BITS-1:0]   RECOVER_HIGH_RST    = SAMPLE_BITS'(581);
    localparam logic [DEBOUNCE_BITS-1:0] SUPPLY_DEBOUNCE_RST = DEBOUNCE_BITS'(250);
    localparam logic [DEBOUNCE_BITS-1:0] FAULT_DEBOUNCE_RST  = DEBOUNCE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0]   OFF_LEAK_LIMIT_RST  = SAMPLE_BITS'(15);
    localparam logic [SAMPLE_BITS-1:0]   FAN_TOLERANCE_RST   = SAMPLE_BITS'(20);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OVER_THRESHOLD  = 3'd0,
        REG_UNDER_THRESHOLD = 3'd1,
        REG_RECOVER_LOW     = 3'd2,
        REG_RECOVER_HIGH    = 3'd3,
        REG_SUPPLY_DEBOUNCE = 3'd4,
        REG_FAULT_DEBOUNCE  = 3'd5,
        REG_OFF_LEAK_LIMIT  = 3'd6,
        REG_FAN_TOLERANCE   = 3'd7
    } cfg_reg_t;

endpackage

// ----- rtl/core/sbfm_sample_if.sv -----
// ----------------------------------------------------------------------------
// sbfm_sample_if
// Sample channel: one supply, fan high and fan low sample plus fan command.
// ----------------------------------------------------------------------------
interface sbfm_sample_if;

    logic                             valid;
    logic                             ready;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] supply_sample;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] fan_high_sample;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] fan_low_sample;
    logic                             fan_on;

    modport source (
        output valid,
        output supply_sample,
        output fan_high_sample,
        output fan_low_sample,
        output fan_on,
        input  ready
    );

    modport sink (
        input  valid,
        input  supply_sample,
        input  fan_high_sample,
        input  fan_low_sample,
        input  fan_on,
        output ready
    );

endinterface

// ----- rtl/core/sbfm_result_if.sv -----
// ----------------------------------------------------------------------------
// sbfm_result_if
// Result channel: group completion, latest averages and status flags.
// ----------------------------------------------------------------------------
interface sbfm_result_if;

    logic                             valid;
    logic                             ready;
    logic                             group_done;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] supply_average;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] fan_high_average;
    logic [sbfm_pkg::SAMPLE_BITS-1:0] fan_low_average;
    logic                             over_voltage;
    logic                             under_voltage;
    logic                             supply_error;
    logic                             blower_fault;

    modport source (
        output valid,
        output group_done,
        output supply_average,
        output fan_high_average,
        output fan_low_average,
        output over_voltage,
        output under_voltage,
        output supply_error,
        output blower_fault,
        input  ready
    );

    modport sink (
        input  valid,
        input  group_done,
        input  supply_average,
        input  fan_high_average,
        input  fan_low_average,
        input  over_voltage,
        input  under_voltage,
        input  supply_error,
        input  blower_fault,
        output ready
    );

endinterface

// ----- rtl/core/sbfm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sbfm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbfm_cfg_if;

    logic                                valid;
    logic                                ready;
    logic [sbfm_pkg::CFG_INDEX_BITS-1:0] index;
    logic [sbfm_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid,
        output index,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  index,
        input  data,
        output ready
    );

endinterface

// ----- rtl/core/supply_and_blower_fault_monitor.sv -----
// ----------------------------------------------------------------------------
// supply_and_blower_fault_monitor
// Path: a sample transfer reaches its result through the input stage, then
//   the result register; throughput, unless the result channel stalls, is one
//   sample per cycle, set by the compute stage updating sums, counters and flags.
// Reset: registers take their default values, sums, averages and counters
//   clear, supply_error sets and the other flags clear; no clearing pass.
// ----------------------------------------------------------------------------
module supply_and_blower_fault_monitor #(
    parameter int GROUP_SIZE = sbfm_pkg::GROUP_SIZE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sbfm_sample_if.sink          samples,
    sbfm_result_if.source        results,
    sbfm_cfg_if.sink             cfg
);

    localparam int SB        = sbfm_pkg::SAMPLE_BITS;
    localparam int DB        = sbfm_pkg::DEBOUNCE_BITS;
    localparam int WB        = sbfm_pkg::WRAP_BITS;
    localparam int LOG_GROUP = $clog2(GROUP_SIZE);
    localparam int SLOT_BITS = (LOG_GROUP < 1) ? 1 : LOG_GROUP;
    localparam int SUM_BITS  = SB + LOG_GROUP;
    // reciprocal divide: floor(s / GROUP_SIZE) = (s * RECIP) >> SHIFT for all s
    localparam int SHIFT      = SUM_BITS + LOG_GROUP;
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((2 ** SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);
    localparam logic [SLOT_BITS-1:0]  LAST_SLOT = SLOT_BITS'(GROUP_SIZE - 1);
    localparam int NCH = 3;

    // configuration registers
    logic [SB-1:0] over_threshold_reg;
    logic [SB-1:0] under_threshold_reg;
    logic [SB-1:0] recover_low_reg;
    logic [SB-1:0] recover_high_reg;
    logic [DB-1:0] supply_debounce_reg;
    logic [DB-1:0] fault_debounce_reg;
    logic [SB-1:0] off_leak_limit_reg;
    logic [SB-1:0] fan_tolerance_reg;

    // input stage
    logic          stage_valid_reg, stage_valid_next;
    logic [SB-1:0] stage_sample_reg [NCH];
    logic          stage_fan_on_reg;
    logic          accept;
    logic          advance;

    // monitor state
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [SUM_BITS-1:0]  sum_reg [NCH];
    logic [SUM_BITS-1:0]  sum_next [NCH];
    logic [SB-1:0]        avg_reg [NCH];
    logic [SB-1:0]        avg_next [NCH];
    logic [DB-1:0]        over_cnt_reg, over_cnt_next;
    logic [DB-1:0]        under_cnt_reg, under_cnt_next;
    logic [DB-1:0]        fault_cnt_reg, fault_cnt_next;
    logic                 over_flag_reg, over_flag_next;
    logic                 under_flag_reg, under_flag_next;
    logic                 error_flag_reg, error_flag_next;
    logic                 blower_flag_reg, blower_flag_next;

    // group arithmetic
    logic [SUM_BITS-1:0]  sum_full [NCH];
    logic [PROD_BITS-1:0] prod [NCH];
    logic [SB-1:0]        quot [NCH];
    logic                 close;

    // result register
    logic          res_valid_reg, res_valid_next;
    logic          res_done_reg;
    logic [SB-1:0] res_avg_reg [NCH];
    logic          res_over_reg;
    logic          res_under_reg;
    logic          res_error_reg;
    logic          res_blower_reg;

    // handshakes
    assign advance       = stage_valid_reg && (!res_valid_reg || results.ready);
    assign samples.ready = !stage_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_threshold_reg  <= sbfm_pkg::OVER_THRESHOLD_RST;
            under_threshold_reg <= sbfm_pkg::UNDER_THRESHOLD_RST;
            recover_low_reg     <= sbfm_pkg::RECOVER_LOW_RST;
            recover_high_reg    <= sbfm_pkg::RECOVER_HIGH_RST;
            supply_debounce_reg <= sbfm_pkg::SUPPLY_DEBOUNCE_RST;
            fault_debounce_reg  <= sbfm_pkg::FAULT_DEBOUNCE_RST;
            off_leak_limit_reg  <= sbfm_pkg::OFF_LEAK_LIMIT_RST;
            fan_tolerance_reg   <= sbfm_pkg::FAN_TOLERANCE_RST;
        end
        else if (cfg.valid)
        begin
            case (sbfm_pkg::cfg_reg_t'(cfg.index))
                sbfm_pkg::REG_OVER_THRESHOLD:  over_threshold_reg  <= cfg.data[SB-1:0];
                sbfm_pkg::REG_UNDER_THRESHOLD: under_threshold_reg <= cfg.data[SB-1:0];
                sbfm_pkg::REG_RECOVER_LOW:     recover_low_reg     <= cfg.data[SB-1:0];
                sbfm_pkg::REG_RECOVER_HIGH:    recover_high_reg    <= cfg.data[SB-1:0];
                sbfm_pkg::REG_SUPPLY_DEBOUNCE: supply_debounce_reg <= cfg.data[DB-1:0];
                sbfm_pkg::REG_FAULT_DEBOUNCE:  fault_debounce_reg  <= cfg.data[DB-1:0];
                sbfm_pkg::REG_OFF_LEAK_LIMIT:  off_leak_limit_reg  <= cfg.data[SB-1:0];
                sbfm_pkg::REG_FAN_TOLERANCE:   fan_tolerance_reg   <= cfg.data[SB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input stage control
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_sample_reg[0] <= samples.supply_sample;
            stage_sample_reg[1] <= samples.fan_high_sample;
            stage_sample_reg[2] <= samples.fan_low_sample;
            stage_fan_on_reg    <= samples.fan_on;
        end
    end

    // running sums and group averages by reciprocal multiply
    always_comb
    begin
        close = (slot_reg == LAST_SLOT);
        for (int c = 0; c < NCH; c++)
        begin
            sum_full[c] = sum_reg[c] + SUM_BITS'(stage_sample_reg[c]);
            prod[c]     = PROD_BITS'(sum_full[c]) * PROD_BITS'(RECIP);
            quot[c]     = prod[c][SHIFT +: SB];
        end
    end

    // state update for one sample
    always_comb
    begin
        logic [DB-1:0] over_inc;
        logic [DB-1:0] under_inc;
        logic [DB-1:0] fault_inc;
        logic [SB-1:0] sup;
        logic [SB-1:0] hi;
        logic [SB-1:0] lo;
        logic [WB-1:0] upper;
        logic [WB-1:0] lower;
        logic          fault;

        slot_next        = slot_reg;
        over_cnt_next    = over_cnt_reg;
        under_cnt_next   = under_cnt_reg;
        fault_cnt_next   = fault_cnt_reg;
        over_flag_next   = over_flag_reg;
        under_flag_next  = under_flag_reg;
        error_flag_next  = error_flag_reg;
        blower_flag_next = blower_flag_reg;
        for (int c = 0; c < NCH; c++)
        begin
            sum_next[c] = sum_reg[c];
            avg_next[c] = avg_reg[c];
        end

        sup       = quot[0];
        hi        = quot[1];
        lo        = quot[2];
        over_inc  = over_cnt_reg + DB'(1);
        under_inc = under_cnt_reg + DB'(1);
        fault_inc = fault_cnt_reg + DB'(1);
        upper     = WB'(sup) + WB'(fan_tolerance_reg);
        lower     = WB'(sup) - WB'(fan_tolerance_reg);
        fault     = 1'b0;

        if (advance)
        begin
            if (!close)
            begin
                slot_next = slot_reg + SLOT_BITS'(1);
                for (int c = 0; c < NCH; c++)
                    sum_next[c] = sum_full[c];
            end
            else
            begin
                slot_next = '0;
                for (int c = 0; c < NCH; c++)
                begin
                    sum_next[c] = '0;
                    avg_next[c] = quot[c];
                end

                // supply classification with debounce and recovery band
                if (sup > over_threshold_reg)
                begin
                    over_cnt_next = over_inc;
                    if (over_inc >= supply_debounce_reg)
                    begin
                        over_cnt_next   = '0;
                        over_flag_next  = 1'b1;
                        under_flag_next = 1'b0;
                        error_flag_next = 1'b1;
                    end
                end
                else if (sup < under_threshold_reg)
                begin
                    under_cnt_next = under_inc;
                    if (under_inc >= supply_debounce_reg)
                    begin
                        under_cnt_next  = '0;
                        under_flag_next = 1'b1;
                        over_flag_next  = 1'b0;
                        error_flag_next = 1'b1;
                    end
                end
                else if (sup > recover_low_reg && sup < recover_high_reg)
                begin
                    over_flag_next  = 1'b0;
                    under_flag_next = 1'b0;
                    error_flag_next = 1'b0;
                    over_cnt_next   = '0;
                    under_cnt_next  = '0;
                end

                // blower feedback check, only with a good supply
                if (!error_flag_next)
                begin
                    if (!stage_fan_on_reg)
                        fault = (hi >= off_leak_limit_reg) || (lo >= off_leak_limit_reg);
                    else
                        fault = (WB'(hi) >= upper) || (WB'(hi) <= lower)
                             || (WB'(lo) >= lower);

                    if (fault)
                    begin
                        fault_cnt_next = fault_inc;
                        if (fault_inc >= fault_debounce_reg)
                        begin
                            fault_cnt_next   = '0;
                            blower_flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        fault_cnt_next   = '0;
                        blower_flag_next = 1'b0;
                    end
                end
            end
        end
    end

    // monitor state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            over_cnt_reg    <= '0;
            under_cnt_reg   <= '0;
            fault_cnt_reg   <= '0;
            over_flag_reg   <= 1'b0;
            under_flag_reg  <= 1'b0;
            error_flag_reg  <= 1'b1;
            blower_flag_reg <= 1'b0;
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c] <= '0;
                avg_reg[c] <= '0;
            end
        end
        else
        begin
            slot_reg        <= slot_next;
            over_cnt_reg    <= over_cnt_next;
            under_cnt_reg   <= under_cnt_next;
            fault_cnt_reg   <= fault_cnt_next;
            over_flag_reg   <= over_flag_next;
            under_flag_reg  <= under_flag_next;
            error_flag_reg  <= error_flag_next;
            blower_flag_reg <= blower_flag_next;
            for (int c = 0; c < NCH; c++)
            begin
                sum_reg[c] <= sum_next[c];
                avg_reg[c] <= avg_next[c];
            end
        end
    end

    // result register control
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (results.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // result payload, loaded with the post-update state
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_done_reg   <= close;
            res_over_reg   <= over_flag_next;
            res_under_reg  <= under_flag_next;
            res_error_reg  <= error_flag_next;
            res_blower_reg <= blower_flag_next;
            for (int c = 0; c < NCH; c++)
                res_avg_reg[c] <= avg_next[c];
        end
    end

    // result transfer outputs
    assign results.valid            = res_valid_reg;
    assign results.group_done       = res_done_reg;
    assign results.supply_average   = res_avg_reg[0];
    assign results.fan_high_average = res_avg_reg[1];
    assign results.fan_low_average  = res_avg_reg[2];
    assign results.over_voltage     = res_over_reg;
    assign results.under_voltage    = res_under_reg;
    assign results.supply_error     = res_error_reg;
    assign results.blower_fault     = res_blower_reg;

endmodule
